// ----- src/pfc_pkg.sv -----
// Shared types, constants and key square functions for the Playfair digraph cipher.
package pfc_pkg;

    localparam int LETTER_W = 5;
    localparam int SIDE = 5;
    localparam int CELLS = SIDE * SIDE;
    localparam int SQUARE_W = CELLS * LETTER_W;
    localparam int CFG_DATA_W = 50;
    localparam int CFG_INDEX_W = 2;
    localparam int POS_W = 3;

    localparam logic [LETTER_W-1:0] FILLER_LETTER = 5'd23;

    localparam logic [CFG_INDEX_W-1:0] REG_SQUARE_LOW = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SQUARE_MID = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SQUARE_HIGH = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SHIFT_DIRECTION = 2'd3;

    typedef logic [LETTER_W-1:0] letter_t;
    typedef logic [SQUARE_W-1:0] square_t;

    typedef struct packed {
        letter_t    first;
        letter_t    second;
        logic       last_of_run;
    } digraph_t;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } pos_t;

    // The last matching cell in row-major order wins; no match gives row 0, column 0.
    function automatic pos_t locate(square_t square, letter_t letter);
        pos_t found;
        found = '0;
        for (int n = 0; n < CELLS; n++) begin
            if (square[n*LETTER_W +: LETTER_W] == letter) begin
                found.row = POS_W'(n / SIDE);
                found.col = POS_W'(n % SIDE);
            end
        end
        return found;
    endfunction

    function automatic logic [POS_W-1:0] step_pos(logic [POS_W-1:0] v, logic backwards);
        logic [POS_W-1:0] r;
        if (backwards) begin
            r = (v == '0) ? POS_W'(SIDE - 1) : v - POS_W'(1);
        end else begin
            r = (v == POS_W'(SIDE - 1)) ? '0 : v + POS_W'(1);
        end
        return r;
    endfunction

    function automatic letter_t cell_at(square_t square, logic [POS_W-1:0] row,
                                        logic [POS_W-1:0] col);
        letter_t picked;
        picked = '0;
        for (int n = 0; n < CELLS; n++) begin
            if (row == POS_W'(n / SIDE) && col == POS_W'(n % SIDE)) begin
                picked = square[n*LETTER_W +: LETTER_W];
            end
        end
        return picked;
    endfunction

endpackage

// ----- src/pfc_pair.sv -----
// Pairs message letters into digraphs, inserting and padding with the filler letter.
module pfc_pair (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  pfc_pkg::letter_t    s_letter,
    input  logic                s_last_in_message,
    output logic                dg_valid,
    input  logic                dg_ready,
    output pfc_pkg::digraph_t   dg
);
    import pfc_pkg::*;

    logic       held_valid_reg, held_valid_next;
    letter_t    held_letter_reg, held_letter_next;
    logic       extra_valid_reg, extra_valid_next;
    letter_t    extra_letter_reg, extra_letter_next;
    logic       dg_valid_reg, dg_valid_next;
    digraph_t   dg_reg, dg_next;
    logic       take;
    logic       slot_free;

    assign slot_free = !dg_valid_reg || dg_ready;
    assign s_ready = !extra_valid_reg && slot_free;
    assign take = s_valid && s_ready;
    assign dg_valid = dg_valid_reg;
    assign dg = dg_reg;

    always_comb begin
        held_valid_next = held_valid_reg;
        held_letter_next = held_letter_reg;
        extra_valid_next = extra_valid_reg;
        extra_letter_next = extra_letter_reg;
        dg_valid_next = dg_valid_reg && !dg_ready;
        dg_next = dg_reg;
        if (take) begin
            if (!held_valid_reg) begin
                if (s_last_in_message) begin
                    dg_valid_next = 1'b1;
                    dg_next = '{first: s_letter, second: FILLER_LETTER, last_of_run: 1'b1};
                end else begin
                    held_valid_next = 1'b1;
                    held_letter_next = s_letter;
                end
            end else if (held_letter_reg != s_letter) begin
                dg_valid_next = 1'b1;
                dg_next = '{first: held_letter_reg, second: s_letter,
                            last_of_run: s_last_in_message};
                held_valid_next = 1'b0;
                held_letter_next = '0;
            end else begin
                dg_valid_next = 1'b1;
                dg_next = '{first: held_letter_reg, second: FILLER_LETTER, last_of_run: 1'b0};
                if (s_last_in_message) begin
                    extra_valid_next = 1'b1;
                    extra_letter_next = s_letter;
                    held_valid_next = 1'b0;
                    held_letter_next = '0;
                end
            end
        end else if (extra_valid_reg && slot_free) begin
            dg_valid_next = 1'b1;
            dg_next = '{first: extra_letter_reg, second: FILLER_LETTER, last_of_run: 1'b1};
            extra_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_valid_reg <= 1'b0;
            held_letter_reg <= '0;
            extra_valid_reg <= 1'b0;
            dg_valid_reg <= 1'b0;
        end else begin
            held_valid_reg <= held_valid_next;
            held_letter_reg <= held_letter_next;
            extra_valid_reg <= extra_valid_next;
            dg_valid_reg <= dg_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        extra_letter_reg <= extra_letter_next;
        dg_reg <= dg_next;
    end

    // A pending padded digraph always waits behind a loaded digraph.
    assert property (@(posedge aclk) disable iff (!aresetn)
        extra_valid_reg |-> dg_valid_reg)
        else $error("padded digraph pending without a loaded digraph");

    assert property (@(posedge aclk) disable iff (!aresetn)
        extra_valid_reg |-> !held_valid_reg)
        else $error("letter held while a padded digraph is pending");

    assert property (@(posedge aclk) disable iff (!aresetn)
        dg_valid_reg && dg_reg.last_of_run |-> !held_valid_reg)
        else $error("letter held behind the final digraph of a message");

endmodule

// ----- src/pfc_lookup.sv -----
// Maps one digraph through the key square into the registered result.
module pfc_lookup (
    input  logic                aclk,
    input  logic                aresetn,
    input  pfc_pkg::square_t    square,
    input  logic                shift_direction,
    input  logic                dg_valid,
    output logic                dg_ready,
    input  pfc_pkg::digraph_t   dg,
    output logic                m_valid,
    input  logic                m_ready,
    output pfc_pkg::letter_t    m_first_out,
    output pfc_pkg::letter_t    m_second_out,
    output logic                m_last_of_run
);
    import pfc_pkg::*;

    pos_t       pa, pb;
    pos_t       oa, ob;
    logic       take;
    logic       m_valid_reg, m_valid_next;
    letter_t    m_first_reg, m_second_reg;
    logic       m_last_reg;

    assign dg_ready = !m_valid_reg || m_ready;
    assign take = dg_valid && dg_ready;

    always_comb begin
        pa = locate(square, dg.first);
        pb = locate(square, dg.second);
        if (pa.row == pb.row) begin
            oa = '{row: pa.row, col: step_pos(pa.col, shift_direction)};
            ob = '{row: pb.row, col: step_pos(pb.col, shift_direction)};
        end else if (pa.col == pb.col) begin
            oa = '{row: step_pos(pa.row, shift_direction), col: pa.col};
            ob = '{row: step_pos(pb.row, shift_direction), col: pb.col};
        end else begin
            oa = '{row: pa.row, col: pb.col};
            ob = '{row: pb.row, col: pa.col};
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        if (take) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            m_first_reg <= cell_at(square, oa.row, oa.col);
            m_second_reg <= cell_at(square, ob.row, ob.col);
            m_last_reg <= dg.last_of_run;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_first_out = m_first_reg;
    assign m_second_out = m_second_reg;
    assign m_last_of_run = m_last_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        take |=> m_valid_reg)
        else $error("taken digraph did not reach the result register");

    assert property (@(posedge aclk) disable iff (!aresetn)
        take |=> m_last_reg == $past(dg.last_of_run))
        else $error("final-digraph flag lost in the lookup stage");

    // Equal letters share one cell, so they map to one cell as well.
    assert property (@(posedge aclk) disable iff (!aresetn)
        take && dg.first == dg.second |=> m_first_reg == m_second_reg)
        else $error("equal letters produced different results");

endmodule

// ----- src/playfair_digraph_cipher.sv -----
// A letter that completes a digraph is captured first in the pairing register and then in the
// result register, which drives the output.
// One letter request per cycle while the output accepts results; a doubled letter that ends a
// message produces two digraphs, and the input then waits while the padded digraph goes out.
// Reset (synchronous, active low) clears the held letter, all valid flags, the key square and
// the direction register; no result is pending after reset.
module playfair_digraph_cipher (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [pfc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [pfc_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [pfc_pkg::LETTER_W-1:0]        s_letter,
    input  logic                                s_last_in_message,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [pfc_pkg::LETTER_W-1:0]        m_first_out,
    output logic [pfc_pkg::LETTER_W-1:0]        m_second_out,
    output logic                                m_last_of_run
);
    import pfc_pkg::*;

    logic [CFG_DATA_W-1:0]      sq_low_reg;
    logic [CFG_DATA_W-1:0]      sq_mid_reg;
    logic [SIDE*LETTER_W-1:0]   sq_high_reg;
    logic                       dir_reg;
    square_t                    square;
    logic                       dg_valid;
    logic                       dg_ready;
    digraph_t                   dg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_low_reg <= '0;
            sq_mid_reg <= '0;
            sq_high_reg <= '0;
            dir_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_SQUARE_LOW: sq_low_reg <= cfg_data;
                REG_SQUARE_MID: sq_mid_reg <= cfg_data;
                REG_SQUARE_HIGH: sq_high_reg <= cfg_data[SIDE*LETTER_W-1:0];
                REG_SHIFT_DIRECTION: dir_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign square = {sq_high_reg, sq_mid_reg, sq_low_reg};

    pfc_pair u_pair (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_letter          (s_letter),
        .s_last_in_message (s_last_in_message),
        .dg_valid          (dg_valid),
        .dg_ready          (dg_ready),
        .dg                (dg)
    );

    pfc_lookup u_lookup (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .square          (square),
        .shift_direction (dir_reg),
        .dg_valid        (dg_valid),
        .dg_ready        (dg_ready),
        .dg              (dg),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_first_out     (m_first_out),
        .m_second_out    (m_second_out),
        .m_last_of_run   (m_last_of_run)
    );

endmodule
